@@ hw/rtl/sact_pkg.sv @@
// ----------------------------------------------------------------------------
// Set-associative cache tag store: shared package
// Types and fixed widths used by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sact_pkg;

  // Fixed widths of the stream payloads.
  localparam int ADDR_W    = 32;
  localparam int SET_OUT_W = 6;
  localparam int COUNT_W   = 32;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 72;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the request and read its set
    logic commit;   // compare, update the set and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/sact_ctrl.sv @@
// ----------------------------------------------------------------------------
// Set-associative cache tag store: controller
// Two-state sequencer that captures a request and then commits its lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire sact_pkg::sts_t sts_i,
  output sact_pkg::cmd_t     cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  state_e state_q;
  logic   in_ready_q;

  assign in_ready_o     = in_ready_q;
  assign cmd_o.capture  = in_valid_i & in_ready_q;
  assign cmd_o.commit   = (state_q == ST_UPDATE) & sts_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= ST_UPDATE;
            in_ready_q <= 1'b0;
          end
        end
        ST_UPDATE: begin
          // Wait here while an earlier result is still held at the output.
          if (sts_i.out_free) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= ST_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sact_dp.sv @@
// ----------------------------------------------------------------------------
// Set-associative cache tag store: datapath
// Tag and pointer memories, valid bits, tag compare, counters, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sact_dp #(
  parameter int ADDR_BITS   = 32,
  parameter int OFFSET_BITS = 4,
  parameter int INDEX_BITS  = 6,
  parameter int WAYS        = 2
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire sact_pkg::cmd_t                    cmd_i,
  output sact_pkg::sts_t                         sts_o,
  input  wire logic [sact_pkg::ADDR_W-1:0]       addr_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [sact_pkg::OUT_DATA_W-1:0]        out_data_o
);

  localparam int EFF_BITS = (ADDR_BITS < sact_pkg::ADDR_W) ? ADDR_BITS : sact_pkg::ADDR_W;
  localparam int TAG_LSB  = OFFSET_BITS + INDEX_BITS;
  localparam int TAG_BITS = (EFF_BITS > TAG_LSB) ? (EFF_BITS - TAG_LSB) : 1;
  localparam int IDX_W    = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int SETS     = 1 << INDEX_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W    = WAYS * TAG_BITS;
  localparam logic [sact_pkg::ADDR_W-1:0] EFF_MASK =
    (EFF_BITS >= sact_pkg::ADDR_W) ? {sact_pkg::ADDR_W{1'b1}} :
    sact_pkg::ADDR_W'((64'd1 << EFF_BITS) - 64'd1);
  localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

  // Storage. Tags and pointers sit in memories; valid bits in flip-flops.
  logic [ROW_W-1:0]  tag_mem [SETS];
  logic [WAY_W-1:0]  ptr_mem [SETS];
  logic [WAYS-1:0]   vld_q   [SETS];
  logic [SETS-1:0]   ptr_vld_q;

  // Captured request and registered memory read data.
  logic [IDX_W-1:0]    set_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [ROW_W-1:0]    row_q;
  logic [WAY_W-1:0]    ptr_q;
  logic [WAYS-1:0]     vld_row_q;

  logic [sact_pkg::COUNT_W-1:0] hits_q, hits_d;
  logic [sact_pkg::COUNT_W-1:0] misses_q, misses_d;

  logic                            out_valid_q;
  logic [sact_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  // Field extraction from the incoming address.
  logic [sact_pkg::ADDR_W-1:0] addr_m, idx_sh, tag_sh;
  logic [IDX_W-1:0]            set_in;
  logic [TAG_BITS-1:0]         tag_in;

  assign addr_m = addr_i & EFF_MASK;
  assign idx_sh = addr_m >> OFFSET_BITS;
  assign tag_sh = addr_m >> TAG_LSB;
  assign set_in = (INDEX_BITS > 0) ? idx_sh[IDX_W-1:0] : '0;
  assign tag_in = (EFF_BITS > TAG_LSB) ? tag_sh[TAG_BITS-1:0] : '0;

  // Lookup on the captured set.
  logic [WAYS-1:0]    vld_row;
  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  logic [WAY_W-1:0]   ptr_cur;
  logic [WAY_W-1:0]   ptr_nxt;
  logic [WAY_W-1:0]   way_sel;
  logic [ROW_W-1:0]   new_row;
  logic [31:0]        set_ext;

  assign vld_row = vld_row_q;
  // A pointer never written reads as way zero.
  assign ptr_cur = ptr_vld_q[set_q] ? ptr_q : '0;
  assign ptr_nxt = (ptr_cur == LAST_WAY) ? '0 : ptr_cur + WAY_W'(1);
  assign set_ext = 32'(set_q);

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    // Downward scan so the lowest matching way wins.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vld_row[w] && (row_q[w*TAG_BITS +: TAG_BITS] == tag_q)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      new_row[w*TAG_BITS +: TAG_BITS] =
        (WAY_W'(w) == ptr_cur) ? tag_q : row_q[w*TAG_BITS +: TAG_BITS];
    end
  end

  assign way_sel = hit ? hit_way : ptr_cur;

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    if (hit) begin
      if (hits_q != sact_pkg::COUNT_MAX) begin
        hits_d = hits_q + sact_pkg::COUNT_W'(1);
      end
    end else begin
      if (misses_q != sact_pkg::COUNT_MAX) begin
        misses_d = misses_q + sact_pkg::COUNT_W'(1);
      end
    end
  end

  // Result packing, lowest bit up: hit, way, set_index, hit_count, miss_count.
  assign out_data_d = {misses_d, hits_d, set_ext[sact_pkg::SET_OUT_W-1:0],
                       way_sel[0], hit};

  // Memory ports: read at capture, write at commit on a miss.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      set_q     <= set_in;
      tag_q     <= tag_in;
      row_q     <= tag_mem[set_in];
      ptr_q     <= ptr_mem[set_in];
      vld_row_q <= vld_q[set_in];
    end
    if (cmd_i.commit && !hit) begin
      tag_mem[set_q] <= new_row;
      ptr_mem[set_q] <= ptr_nxt;
    end
    if (cmd_i.commit) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SETS; s++) begin
        vld_q[s] <= '0;
      end
      ptr_vld_q   <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        hits_q   <= hits_d;
        misses_q <= misses_d;
        if (!hit) begin
          vld_q[set_q][ptr_cur] <= 1'b1;
          ptr_vld_q[set_q]      <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/set_assoc_cache_rr_tags.sv @@
// A request is captured together with the registered read of its set's tag row, then
// committed into the result register once no earlier result is waiting at the output.
// A new request is accepted only after the previous one has committed, because of the
// registered read of the set's tag row and the compare-and-write that follows on that row.
// Reset: valid bits, pointer valid bits and both counters clear at once; no clearing pass.
// ----------------------------------------------------------------------------
// Set-associative cache tag store with round-robin replacement
// Looks up each address in its set, counts hits and misses and fills on a miss.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_rr_tags #(
  parameter int ADDR_BITS   = 32,
  parameter int OFFSET_BITS = 4,
  parameter int INDEX_BITS  = 6,
  parameter int WAYS        = 2
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Request stream.
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [sact_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [31:0] address
  // Result stream.
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [0] hit, [1] way, [7:2] set_index, [39:8] hit_count, [71:40] miss_count
  output logic [sact_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);

  // The controller only sequences; all storage and arithmetic live in the datapath.
  sact_pkg::cmd_t cmd;
  sact_pkg::sts_t sts;

  sact_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The address is captured together with the read of its set's tag row and pointer.
  // Once the result register is free, the tags are compared, the hit or victim way is chosen,
  // a miss writes the row back with the new tag and advances the pointer, and the
  // result with both saturating counters is loaded into the output register. That
  // register holds a result while the next request is already being accepted.
  sact_dp #(
    .ADDR_BITS   (ADDR_BITS),
    .OFFSET_BITS (OFFSET_BITS),
    .INDEX_BITS  (INDEX_BITS),
    .WAYS        (WAYS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .addr_i      (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // A capture is never followed directly by another one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> !s_axis_tready)
    else $error("request accepted while a lookup was in progress");

  // Capture and commit never fall in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");

  // A commit always presents a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid)
    else $error("committed lookup produced no result");

endmodule

`default_nettype wire

@@ verif/set_assoc_cache_rr_tags_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the round-robin set-associative cache tag store
// Streams byte addresses into the block and checks each lookup result, field
// by field, against a behavioural model of the tags, victim pointers and counters.
// ----------------------------------------------------------------------------

module set_assoc_cache_rr_tags_tb;

  localparam int HALF_PERIOD = 2;
  localparam int OFFSET_BITS = 4;
  localparam int INDEX_BITS  = 6;
  localparam int WAYS        = 2;
  localparam int SETS        = 1 << INDEX_BITS;
  localparam int TAG_W       = sact_pkg::ADDR_W - OFFSET_BITS - INDEX_BITS;
  localparam int QUIET_LIMIT = 2000;  // cycles without any handshake before giving up
  localparam int DRAIN_WAIT  = 10;
  localparam int PHASES      = 7;
  localparam int PHASE_LEN   = 100;
  localparam int MAX_REPORTS = 40;

  // One expected lookup result, in the order of the fields on the result stream.
  typedef struct {
    logic                           hit;
    logic                           way;
    logic [sact_pkg::SET_OUT_W-1:0] set_index;
    logic [sact_pkg::COUNT_W-1:0]   hit_count;
    logic [sact_pkg::COUNT_W-1:0]   miss_count;
  } lookup_t;

  // Scoreboard: keeps its own copy of the tag store and predicts every lookup.
  class tag_scoreboard;
    bit                           line_valid [SETS][WAYS];
    logic [TAG_W-1:0]             line_tag   [SETS][WAYS];
    int                           victim     [SETS];
    logic [sact_pkg::COUNT_W-1:0] hits;
    logic [sact_pkg::COUNT_W-1:0] misses;
    lookup_t                      expected_lookups[$];
    int                           errors;
    int                           checked;

    function new();
      hits    = '0;
      misses  = '0;
      errors  = 0;
      checked = 0;
      foreach (line_tag[s, w]) line_tag[s][w] = '0;
      foreach (victim[s]) victim[s] = 0;
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction

    // A request was accepted: look it up in the model and queue the outcome.
    function void note_access(logic [sact_pkg::ADDR_W-1:0] addr);
      int                    set;
      int                    w;
      int                    way_sel;
      bit                    found;
      logic [TAG_W-1:0]      tag;
      lookup_t               r;
      set     = int'(addr[OFFSET_BITS +: INDEX_BITS]);
      tag     = addr[sact_pkg::ADDR_W-1 -: TAG_W];
      found   = 1'b0;
      way_sel = 0;
      // The lowest-numbered valid way that matches wins.
      for (w = 0; w < WAYS; w++) begin
        if (!found && line_valid[set][w] && line_tag[set][w] == tag) begin
          found   = 1'b1;
          way_sel = w;
        end
      end
      if (found) begin
        if (hits != sact_pkg::COUNT_MAX) hits = hits + sact_pkg::COUNT_W'(1);
      end else begin
        // The fill always goes to the victim pointer, even if another way is empty.
        way_sel = victim[set];
        if (misses != sact_pkg::COUNT_MAX) misses = misses + sact_pkg::COUNT_W'(1);
        line_valid[set][way_sel] = 1'b1;
        line_tag[set][way_sel]   = tag;
        victim[set]              = (way_sel + 1) % WAYS;
      end
      r.hit        = found;
      r.way        = way_sel[0];
      r.set_index  = set[sact_pkg::SET_OUT_W-1:0];
      r.hit_count  = hits;
      r.miss_count = misses;
      expected_lookups.push_back(r);
    endfunction

    task report_mismatch(string what, logic [sact_pkg::COUNT_W-1:0] got,
                         logic [sact_pkg::COUNT_W-1:0] want);
      if (errors < MAX_REPORTS)
        $display("mismatch in result %0d: %0s got 0x%0h, expected 0x%0h",
                 checked, what, got, want);
      errors++;
    endtask

    // A result was accepted: compare it with the oldest outstanding lookup.
    task check_result(logic [sact_pkg::OUT_DATA_W-1:0] d);
      lookup_t want;
      if (expected_lookups.size() == 0) begin
        report_mismatch("unexpected result, data low word", d[31:0], '0);
      end else begin
        want = expected_lookups.pop_front();
        if (d[0] !== want.hit)
          report_mismatch("hit", sact_pkg::COUNT_W'(d[0]), sact_pkg::COUNT_W'(want.hit));
        if (d[1] !== want.way)
          report_mismatch("way", sact_pkg::COUNT_W'(d[1]), sact_pkg::COUNT_W'(want.way));
        if (d[7:2] !== want.set_index)
          report_mismatch("set_index", sact_pkg::COUNT_W'(d[7:2]),
                          sact_pkg::COUNT_W'(want.set_index));
        if (d[39:8] !== want.hit_count)
          report_mismatch("hit_count", d[39:8], want.hit_count);
        if (d[71:40] !== want.miss_count)
          report_mismatch("miss_count", d[71:40], want.miss_count);
      end
      checked++;
    endtask
  endclass

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [sact_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [31:0] address
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [0] hit, [1] way, [7:2] set_index, [39:8] hit_count, [71:40] miss_count
  logic [sact_pkg::OUT_DATA_W-1:0] m_axis_tdata;

  tag_scoreboard sb = new();

  bit tx_throttle = 1'b1;  // sender leaves random gaps between requests
  bit rx_throttle = 1'b1;  // receiver stalls at random
  int rx_left     = 0;
  int quiet       = 0;

  set_assoc_cache_rr_tags #(
    .ADDR_BITS  (sact_pkg::ADDR_W),
    .OFFSET_BITS(OFFSET_BITS),
    .INDEX_BITS (INDEX_BITS),
    .WAYS       (WAYS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Mostly no pause, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [sact_pkg::ADDR_W-1:0] make_addr(logic [TAG_W-1:0] tag, int set,
                                                            int offset);
    return {tag, set[INDEX_BITS-1:0], offset[OFFSET_BITS-1:0]};
  endfunction

  // Outputs are sampled at the rising edge, before any of that edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_access(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // Receiver: alternates runs of readiness with stalls of random length; unthrottled it stays ready.
  always @(posedge clk_i) begin
    if (rx_left != 0) begin
      rx_left--;
    end else if (!rx_throttle || !m_axis_tready) begin
      m_axis_tready <= 1'b1;
      rx_left = $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b0;
      rx_left = pick_gap();
    end
  end

  // Watchdog: the run is hung if no request and no result moves for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog expired with %0d lookups outstanding", sb.pending());
      $display("FAIL set_assoc_cache_rr_tags");
      $finish;
    end
  end

  // Presents one request and returns at the edge that accepts it.
  task automatic send_access(logic [sact_pkg::ADDR_W-1:0] addr);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Optionally drops valid for a random number of cycles after a request.
  task automatic sender_pause();
    int g;
    g = tx_throttle ? pick_gap() : 0;
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [sact_pkg::ADDR_W-1:0] directed[$];
    logic [TAG_W-1:0]            tag_pool[4];
    logic [sact_pkg::ADDR_W-1:0] a;
    int                          last_set;
    int                          set;
    int                          p;
    int                          n;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The model's tags are all zero after reset but invalid, so the very
    // first access must miss.
    directed.push_back(make_addr('0, 0, 0));
    directed.push_back(make_addr('0, 0, 0));
    directed.push_back(make_addr('0, 0, 15));
    directed.push_back(32'hFFFF_FFFF);
    directed.push_back(32'hFFFF_FFF0);
    // Fill both ways of the last set, then keep evicting in round-robin order.
    directed.push_back(make_addr(22'h3FFFFE, 63, 0));
    directed.push_back(make_addr('0, 63, 8));
    directed.push_back(make_addr(22'h3FFFFF, 63, 0));
    directed.push_back(make_addr(22'h3FFFFE, 63, 15));
    directed.push_back(make_addr(22'h3FFFFF, 63, 3));
    // Back-to-back accesses to one set, mixing hits and fills.
    directed.push_back(make_addr(22'd1, 10, 0));
    directed.push_back(make_addr(22'd2, 10, 1));
    directed.push_back(make_addr(22'd1, 10, 2));
    directed.push_back(make_addr(22'd2, 10, 3));
    directed.push_back(make_addr(22'd3, 10, 4));
    directed.push_back(make_addr(22'd1, 10, 5));
    // Walking one across the set index, with alternating tag patterns.
    for (n = 0; n < INDEX_BITS; n++)
      directed.push_back(make_addr(n[0] ? 22'h2AAAAA : 22'h155555, 1 << n, n));
    // Another untouched set: an empty way holding tag zero must not hit.
    directed.push_back(make_addr('0, 5, 0));

    tx_throttle = 1'b0;
    foreach (directed[i]) send_access(directed[i]);
    tx_throttle = 1'b1;

    // Random part. Most requests pick from a few tags in a few sets so that
    // hits, fills and evictions all happen often; the rest are arbitrary.
    foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom());
    last_set = 0;
    for (p = 0; p < PHASES; p++) begin
      // Some phases run flat out on both sides.
      tx_throttle = !(p == 2 || p == 5);
      rx_throttle = tx_throttle;
      for (n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 99) < 70) begin
          set = ($urandom_range(0, 3) == 0) ? last_set : $urandom_range(0, 7);
          a   = make_addr(tag_pool[$urandom_range(0, 3)], set, $urandom_range(0, 15));
        end else begin
          a = $urandom();
        end
        last_set = int'(a[OFFSET_BITS +: INDEX_BITS]);
        send_access(a);
        sender_pause();
      end
      // Once, hold the sender back until every outstanding lookup has returned.
      if (p == 3) begin
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
    end
    rx_throttle   = 1'b1;
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("PASS set_assoc_cache_rr_tags");
    end else begin
      $display("FAIL set_assoc_cache_rr_tags");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/sact_pkg.sv
hw/rtl/sact_ctrl.sv
hw/rtl/sact_dp.sv
hw/rtl/set_assoc_cache_rr_tags.sv
verif/set_assoc_cache_rr_tags_tb.sv
